// ===== rtl/core/sma_pkg.sv =====
// ----------------------------------------------------------------------------
// sma_pkg
// fixed port widths and register constants shared by the moving average block
// ----------------------------------------------------------------------------
package sma_pkg;

	// width of the window length register write data
	localparam int CFG_W = 7;

	// width of the price sample port (Q16.16)
	localparam int PRICE_IN_W = 32;

	// width of the average result port (Q16.16)
	localparam int AVG_W = 32;

	// window length after reset
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd5;

endpackage

// ===== rtl/core/sma_front.sv =====
// ----------------------------------------------------------------------------
// sma_front
// sample intake: ring store, running window sum and fill count
// ----------------------------------------------------------------------------
module sma_front #(
	parameter int MAX_WINDOW  = 64,
	parameter int PRICE_WIDTH = 32,
	localparam int IDX_W = $clog2(MAX_WINDOW),
	localparam int LEN_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = PRICE_WIDTH + $clog2(MAX_WINDOW)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [sma_pkg::PRICE_IN_W-1:0] close_price,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic [sma_pkg::CFG_W-1:0]      window_length,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	output logic                           push_valid,
	input  logic                           push_ready,
	output logic [SUM_W-1:0]               push_sum,
	output logic [LEN_W-1:0]               push_len,
	output logic                           push_vld
);
	import sma_pkg::*;

	localparam int AW = IDX_W + 1;

	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
		logic [LEN_W-1:0] r;
		if (v == '0) begin
			r = LEN_W'(1);
		end else if (int'(v) > MAX_WINDOW) begin
			r = LEN_W'(MAX_WINDOW);
		end else begin
			r = LEN_W'(v);
		end
		return r;
	endfunction

	localparam logic [LEN_W-1:0] LEN_RESET = eff_len(WINDOW_RESET);

	logic [PRICE_WIDTH-1:0] mem [MAX_WINDOW];
	logic [PRICE_WIDTH-1:0] sample_s1;
	logic [PRICE_WIDTH-1:0] old_s1;
	logic                   drop_s1;
	logic                   busy_q;
	logic [LEN_W-1:0]       len_q;
	logic [LEN_W-1:0]       seen_q;
	logic [IDX_W-1:0]       pos_q;
	logic [SUM_W-1:0]       sum_q;

	logic             accept;
	logic             cfg_accept;
	logic [AW-1:0]    old_base;
	logic [IDX_W-1:0] old_addr;
	logic [SUM_W-1:0] sum_next;
	logic [LEN_W-1:0] seen_next;
	logic [IDX_W-1:0] pos_next;

	assign sample_ready = !busy_q && push_ready;
	assign cfg_ready    = 1'b1;
	assign accept       = sample_valid && sample_ready;
	assign cfg_accept   = cfg_valid && cfg_ready;

	// oldest window entry: pos - len, modulo the store depth
	always_comb begin
		old_base = AW'(pos_q) + AW'(MAX_WINDOW) - AW'(len_q);
		if (old_base >= AW'(MAX_WINDOW)) begin
			old_addr = IDX_W'(old_base - AW'(MAX_WINDOW));
		end else begin
			old_addr = IDX_W'(old_base);
		end
	end

	always_comb begin
		sum_next = sum_q + SUM_W'(sample_s1);
		if (drop_s1) begin
			sum_next = sum_next - SUM_W'(old_s1);
		end
		seen_next = (seen_q == LEN_W'(MAX_WINDOW)) ? seen_q : seen_q + LEN_W'(1);
		pos_next  = (pos_q == IDX_W'(MAX_WINDOW - 1)) ? '0 : pos_q + IDX_W'(1);
	end

	assign push_valid = busy_q;
	assign push_sum   = sum_next;
	assign push_len   = len_q;
	assign push_vld   = seen_next >= len_q;

	// store read and write
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= PRICE_WIDTH'(close_price);
			old_s1    <= mem[old_addr];
		end
		if (busy_q) begin
			mem[pos_q] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			drop_s1 <= 1'b0;
			len_q   <= LEN_RESET;
			seen_q  <= '0;
			pos_q   <= '0;
			sum_q   <= '0;
		end else begin
			if (cfg_accept) begin
				len_q  <= eff_len(window_length);
				seen_q <= '0;
				pos_q  <= '0;
				sum_q  <= '0;
			end else if (busy_q) begin
				seen_q <= seen_next;
				pos_q  <= pos_next;
				sum_q  <= sum_next;
			end
			if (accept) begin
				busy_q  <= 1'b1;
				drop_s1 <= seen_q >= len_q;
			end else if (busy_q) begin
				busy_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> push_ready)
		else $error("update cycle found the queue full");
	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= LEN_W'(MAX_WINDOW))
		else $error("fill count beyond store depth");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= IDX_W'(MAX_WINDOW - 1))
		else $error("write position out of range");
`endif

endmodule

// ===== rtl/core/sma_queue.sv =====
// ----------------------------------------------------------------------------
// sma_queue
// two-entry queue between intake and divider
// ----------------------------------------------------------------------------
module sma_queue #(
	parameter int DATA_W = 46
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);
	import sma_pkg::*;

	logic [DATA_W-1:0] ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = ent_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/core/sma_back.sv =====
// ----------------------------------------------------------------------------
// sma_back
// bit-serial divider for sum / length and the result register
// ----------------------------------------------------------------------------
module sma_back #(
	parameter int MAX_WINDOW  = 64,
	parameter int PRICE_WIDTH = 32,
	localparam int LEN_W = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W = PRICE_WIDTH + $clog2(MAX_WINDOW)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pop_valid,
	output logic                      pop_ready,
	input  logic [SUM_W-1:0]          pop_sum,
	input  logic [LEN_W-1:0]          pop_len,
	input  logic                      pop_vld,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [sma_pkg::AVG_W-1:0] average,
	output logic                      average_valid
);
	import sma_pkg::*;

	localparam int CNT_W = $clog2(SUM_W);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_HOLD} state_t;

	state_t           state_q;
	logic [SUM_W-1:0] dvd_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             vld_q;
	logic             result_valid_q;
	logic [AVG_W-1:0] average_q;
	logic             average_valid_q;

	logic [LEN_W:0]   rem_sh;
	logic             ge;
	logic [LEN_W:0]   rem_next;

	assign pop_ready     = state_q == ST_IDLE;
	assign result_valid  = result_valid_q;
	assign average       = average_q;
	assign average_valid = average_valid_q;

	// one quotient bit per cycle
	always_comb begin
		rem_sh   = {rem_q, dvd_q[SUM_W-1]};
		ge       = rem_sh >= {1'b0, div_q};
		rem_next = ge ? rem_sh - {1'b0, div_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			dvd_q           <= '0;
			rem_q           <= '0;
			div_q           <= '0;
			cnt_q           <= '0;
			vld_q           <= 1'b0;
			result_valid_q  <= 1'b0;
			average_q       <= '0;
			average_valid_q <= 1'b0;
		end else begin
			// result register: load from hold, else clear once taken
			if (state_q == ST_HOLD && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						rem_q <= '0;
						div_q <= pop_len;
						cnt_q <= CNT_W'(SUM_W - 1);
						vld_q <= pop_vld;
						if (pop_vld) begin
							dvd_q   <= pop_sum;
							state_q <= ST_DIV;
						end else begin
							dvd_q   <= '0;
							state_q <= ST_HOLD;
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_next[LEN_W-1:0];
					dvd_q <= {dvd_q[SUM_W-2:0], ge};
					if (cnt_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_HOLD: begin
					if (!result_valid_q || result_ready) begin
						average_q       <= AVG_W'(dvd_q);
						average_valid_q <= vld_q;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_q != '0)
		else $error("division by zero length");
	a_zero_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !average_valid_q |-> average_q == '0)
		else $error("nonzero average on a not-ready window");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= CNT_W'(SUM_W - 1))
		else $error("divider step count out of range");
`endif

endmodule

// ===== rtl/core/simple_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// simple_moving_average_unit
// moving average of Q16.16 price samples over a programmable window
// ----------------------------------------------------------------------------
// Each accepted close_price request yields one result request holding the
// truncated mean of the newest window_length samples in Q16.16. Until
// window_length samples have arrived since reset or the last register write,
// the result is a zero average with average_valid low. A window length of
// zero acts as one, and values above MAX_WINDOW act as MAX_WINDOW. Writing
// window_length clears the sample history; write it only while the unit is
// idle. The intake side reads the leaving sample from the ring store and
// updates a running sum: a store read step, then a sum update and write
// step. It takes no new sample until that update is done and the queue has
// room. A two-entry queue hands each sum to a restoring divider that
// produces one quotient bit per cycle for a sample whose window is full.
// That divider sets the sustained rate. A sample whose window is not yet
// full skips the divider. The output register lets the next sample move
// through while a result waits.
// ----------------------------------------------------------------------------
module simple_moving_average_unit #(
	parameter int MAX_WINDOW  = 64,
	parameter int PRICE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample channel
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic [sma_pkg::PRICE_IN_W-1:0] close_price,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [sma_pkg::AVG_W-1:0]      average,
	output logic                           average_valid,
	// window length register write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sma_pkg::CFG_W-1:0]      window_length
);
	import sma_pkg::*;

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = PRICE_WIDTH + $clog2(MAX_WINDOW);
	localparam int QW    = 1 + LEN_W + SUM_W;

	// intake to queue
	logic             push_valid;
	logic             push_ready;
	logic [SUM_W-1:0] push_sum;
	logic [LEN_W-1:0] push_len;
	logic             push_vld;

	// queue to divider
	logic             pop_valid;
	logic             pop_ready;
	logic [QW-1:0]    pop_data;

	// ring store, running sum, fill count and window register
	sma_front #(
		.MAX_WINDOW  (MAX_WINDOW),
		.PRICE_WIDTH (PRICE_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.close_price   (close_price),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.window_length (window_length),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_sum      (push_sum),
		.push_len      (push_len),
		.push_vld      (push_vld)
	);

	// entry layout: {window full, length, sum}
	sma_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_vld, push_len, push_sum}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// serial divider and output register
	sma_back #(
		.MAX_WINDOW  (MAX_WINDOW),
		.PRICE_WIDTH (PRICE_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_sum       (pop_data[SUM_W-1:0]),
		.pop_len       (pop_data[SUM_W+LEN_W-1:SUM_W]),
		.pop_vld       (pop_data[QW-1]),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.average       (average),
		.average_valid (average_valid)
	);

endmodule

// ===== tb/sma_checker.sv =====
// ----------------------------------------------------------------------------
// sma_checker
// watches the moving average channels, predicts each result and compares
// ----------------------------------------------------------------------------
// Every accepted sample request runs through a model of the averaging window.
// The model's result is queued. Every accepted result request is compared
// field by field with the oldest queued result. A window length write clears
// the history, the same as the block does.
// ----------------------------------------------------------------------------
module sma_checker #(
	parameter int HIST_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic                           sample_ready,
	input  logic [sma_pkg::PRICE_IN_W-1:0] close_price,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic [sma_pkg::AVG_W-1:0]      average,
	input  logic                           average_valid,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [sma_pkg::CFG_W-1:0]      window_length,
	output int                             mismatches,
	output int                             outstanding
);
	import sma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SUM_W = PRICE_IN_W + $clog2(HIST_DEPTH);
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [AVG_W-1:0] mean;
		logic             full;
	} average_t;

	average_t              expected_averages[$];
	logic [PRICE_IN_W-1:0] history [HIST_DEPTH];
	logic [SUM_W-1:0]      running_sum;
	int unsigned           ring_pos;
	int unsigned           fill_count;
	logic [CFG_W-1:0]      window_reg;

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic clear_history();
		running_sum = '0;
		ring_pos = 0;
		fill_count = 0;
	endtask

	// one step of the window: drop the leaving sample, add the new one
	function automatic average_t next_average(input logic [PRICE_IN_W-1:0] price);
		int unsigned span;
		int unsigned oldest;
		average_t    r;
		if (window_reg == 0)
			span = 1;
		else if (window_reg > HIST_DEPTH)
			span = HIST_DEPTH;
		else
			span = window_reg;
		if (fill_count >= span) begin
			oldest = (ring_pos + HIST_DEPTH - span) % HIST_DEPTH;
			running_sum -= SUM_W'(history[oldest]);
		end
		history[ring_pos] = price;
		running_sum += SUM_W'(price);
		ring_pos = (ring_pos + 1) % HIST_DEPTH;
		if (fill_count < HIST_DEPTH)
			fill_count++;
		if (fill_count >= span) begin
			r.mean = AVG_W'(running_sum / SUM_W'(span));
			r.full = 1'b1;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		average_t want;
		if (!arst_n) begin
			window_reg = WINDOW_RESET;
			clear_history();
			expected_averages.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_reg = window_length;
				clear_history();
			end
			if (result_valid && result_ready) begin
				if (expected_averages.size() == 0) begin
					report_mismatch($sformatf("result %h/%b with nothing expected",
						average, average_valid));
				end else begin
					want = expected_averages.pop_front();
					if (average !== want.mean)
						report_mismatch($sformatf("average %h, expected %h",
							average, want.mean));
					if (average_valid !== want.full)
						report_mismatch($sformatf("average_valid %b, expected %b",
							average_valid, want.full));
				end
			end
			if (sample_valid && sample_ready)
				expected_averages.insert(expected_averages.size(),
					next_average(close_price));
		end
		outstanding <= expected_averages.size();
	end

endmodule

// ===== tb/simple_moving_average_unit_tb.sv =====
// ----------------------------------------------------------------------------
// simple_moving_average_unit_tb
// regression for the moving average unit
// ----------------------------------------------------------------------------
// A short directed run covers the all-zero and all-one prices, the fill-up
// stage and the zero window length. Random phases then sweep the window
// length over its range, including zero and values above the store depth,
// with bursty sample traffic and a stalling result side. A checker beside the
// unit predicts and compares every result; this module only drives traffic
// and prints the verdict.
// ----------------------------------------------------------------------------
module simple_moving_average_unit_tb;
	import sma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 64;
	localparam int PRICE_BITS   = 32;
	localparam int LONG_HOLD_AT = 200;   // results taken before the long hold-off
	localparam int LONG_HOLD    = 400;   // cycles of the long hold-off
	localparam int TAIL_CYCLES  = 60;    // about one divider pass and handoff

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	logic [PRICE_IN_W-1:0] close_price = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [AVG_W-1:0]      average;
	logic                  average_valid;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      window_length = WINDOW_RESET;

	int mismatches;
	int outstanding;

	simple_moving_average_unit #(
		.MAX_WINDOW (DEPTH),
		.PRICE_WIDTH(PRICE_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.close_price  (close_price),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.average      (average),
		.average_valid(average_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_length(window_length)
	);

	sma_checker #(
		.HIST_DEPTH(DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.close_price  (close_price),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.average      (average),
		.average_valid(average_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_length(window_length),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// result side: stretches of random length, each with its own ready odds,
	// plus one long hold-off so the unit backs up into the sample channel
	// ------------------------------------------------------------------------
	int unsigned results_taken = 0;
	int unsigned hold_left = 0;
	int unsigned stretch_left = 0;
	int unsigned ready_odds = 100;
	bit          long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			results_taken++;
		if (!long_hold_done && results_taken >= LONG_HOLD_AT) begin
			hold_left = LONG_HOLD;
			long_hold_done = 1'b1;
		end
		if (stretch_left == 0) begin
			stretch_left = $urandom_range(8, 64);
			case ($urandom_range(0, 3))
				0: ready_odds = 100;    // no stalls at all
				1: ready_odds = 75;
				2: ready_odds = 40;
				default: ready_odds = 10;
			endcase
		end
		stretch_left--;
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(1, 100) <= ready_odds);
		end
	end

	// ------------------------------------------------------------------------
	// sample side: bursts of random length separated by random gaps
	// ------------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned max_gap = 0;

	task automatic send_sample(input logic [PRICE_IN_W-1:0] price);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		sample_valid <= 1'b1;
		close_price <= price;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		burst_left--;
	endtask

	// stop offering and wait until every queued result has come back;
	// the first edge lets a request accepted just now reach the checker
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// window length writes happen only with the unit drained
	task automatic write_window(input logic [CFG_W-1:0] len);
		drain();
		cfg_valid <= 1'b1;
		window_length <= len;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mix of full-range, extreme, one-hot and small prices
	function automatic logic [PRICE_IN_W-1:0] pick_price();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2: return PRICE_IN_W'(1) << $urandom_range(0, PRICE_IN_W - 1);
			3: return PRICE_IN_W'($urandom_range(0, 65535));
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	logic [CFG_W-1:0] phase_windows [11] = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd100,
		7'd63, 7'd65, 7'd5, 7'd0, 7'd3, 7'd64};

	initial begin
		int unsigned count;
		int unsigned ones_run;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, window length left at its reset value of five
		max_gap = 0;
		repeat (4) send_sample('0);              // window still filling
		repeat (5) send_sample('1);              // reaches the all-ones mean
		send_sample(32'h0000_0001);
		send_sample(32'h8000_0000);
		send_sample(32'h0001_0000);
		send_sample(32'h0000_ffff);

		// zero window length behaves as a window of one
		write_window('0);
		send_sample('1);
		send_sample('0);
		send_sample(32'h1234_5678);

		write_window(7'd1);
		send_sample(32'hdead_beef);
		send_sample(32'h0000_0007);

		// random phases across the window length range
		for (int ph = 0; ph < 14; ph++) begin
			if (ph < 11)
				write_window(phase_windows[ph]);
			else
				write_window(CFG_W'($urandom_range(0, 127)));
			max_gap = (ph % 3 == 0) ? 0 : $urandom_range(2, 15);
			burst_left = 0;
			count = (ph == 0) ? 100 : $urandom_range(45, 75);
			// first phase drives a full window of all-ones for the largest sum
			ones_run = (ph == 0) ? 70 : 0;
			for (int n = 0; n < count; n++) begin
				send_sample((n < ones_run) ? '1 : pick_price());
				if ($urandom_range(0, 149) == 0)
					drain();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// safety net well above the slowest correct run
	initial begin
		#2_500_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sma_pkg.sv
rtl/core/sma_front.sv
rtl/core/sma_queue.sv
rtl/core/sma_back.sv
rtl/core/simple_moving_average_unit.sv
tb/sma_checker.sv
tb/simple_moving_average_unit_tb.sv
